[src/dsaq_pkg.sv]
// Shared constants for the deadline sorted alarm queue.
// Field widths, queue depth and the result codes; no dependencies.
`timescale 1ns / 1ps

package dsaq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W   = 64;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;
  localparam int IRQ_W    = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAST    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WOKEN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SUMMARY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam logic [IRQ_W-1:0] IRQ_NONE     = 2'd0;
  localparam logic [IRQ_W-1:0] IRQ_ENABLED  = 2'd1;
  localparam logic [IRQ_W-1:0] IRQ_DISABLED = 2'd2;

endpackage

[src/dsaq_ifs.sv]
// Valid/ready channels of the alarm queue: request words in, result words out.
// Depends on dsaq_pkg for the field widths.
`timescale 1ns / 1ps

interface dsaq_in_if import dsaq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   alarm_id;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] delay_counts;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, req_type, alarm_id, base_time, delay_counts, now_time,
                  input ready);
  modport sink (input valid, req_type, alarm_id, base_time, delay_counts, now_time,
                output ready);
endinterface

interface dsaq_out_if import dsaq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     woken_id;
  logic [TIME_W-1:0]   wake_time;
  logic [TIME_W-1:0]   compare_value;
  logic                compare_written;
  logic [IRQ_W-1:0]    irq_change;
  logic                last;

  modport source (output valid, status, woken_id, wake_time, compare_value,
                  compare_written, irq_change, last, input ready);
  modport sink (input valid, status, woken_id, wake_time, compare_value,
                compare_written, irq_change, last, output ready);
endinterface

[src/deadline_sorted_alarm_queue.sv]
// Alarm queue kept sorted by wake time, with its sequencer and entry storage.
// Depends on dsaq_pkg and the channel interfaces in dsaq_ifs.sv.
`timescale 1ns / 1ps

// Usage:
// in_if carries one request word: a sleep request (req_type 0) or a timer
// interrupt check (req_type 1). out_if returns result words; the final word
// of each request has last set. A sleep request gives one word, an interrupt
// check one word per woken alarm and a closing summary word.
// The block takes one request at a time. A single comparator and a single
// entry read port walk the queue one entry per cycle, except where a result
// word waits for the output register. A sleep request that is already past
// or finds the queue full is answered from the check state without a walk.
// The final word is valid in the cycle in which the block is ready again.
// The first walk finds the insert point or the due entries, the second
// shifts entries up or down.
// When out_if.ready is low the sequencer holds at the next result word and
// resumes when the output register is free.
// Reset empties the queue, sets the compare register to all ones and clears
// the interrupt enable. Entry storage is not cleared; only occupied entries
// are ever read.
module deadline_sorted_alarm_queue import dsaq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dsaq_in_if.sink     in_if,
  dsaq_out_if.source  out_if
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHK     = 3'd1;
  localparam logic [2:0] S_FIND    = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_POP     = 3'd4;
  localparam logic [2:0] S_COMPACT = 3'd5;
  localparam logic [2:0] S_SUM     = 3'd6;

  logic [TIME_W-1:0] wake_q  [QUEUE_DEPTH];
  logic [ID_W-1:0]   owner_q [QUEUE_DEPTH];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  dst_r, dst_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [TIME_W-1:0] key_r, key_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] cmp_r, cmp_nxt;
  logic              irq_en_r, irq_en_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [TIME_W-1:0]   out_wake_r;
  logic [TIME_W-1:0]   out_cmp_r;
  logic                out_cw_r;
  logic [IRQ_W-1:0]    out_irq_r;
  logic                out_last_r;

  logic                emit;
  logic [STATUS_W-1:0] e_status;
  logic [ID_W-1:0]     e_id;
  logic [TIME_W-1:0]   e_wake;
  logic [TIME_W-1:0]   e_cmp;
  logic                e_cw;
  logic [IRQ_W-1:0]    e_irq;
  logic                e_last;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [TIME_W-1:0] wr_wake;
  logic [ID_W-1:0]   wr_owner;

  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_wake;
  logic [ID_W-1:0]   rd_owner;
  logic [TIME_W-1:0] cmp_a;
  logic              le;
  logic              in_range;
  logic              out_free;
  logic [TIME_W:0]   sum_full;
  logic [TIME_W-1:0] sat_wake;
  logic [CNT_W-1:0]  idx_m1;

  assign out_free = !out_valid_r || out_if.ready;
  assign in_range = idx_r < count_r;
  assign idx_m1   = idx_r - CNT_W'(1);

  // Saturating wake time of a sleep request, computed as the word is taken.
  assign sum_full = {1'b0, in_if.base_time} + {1'b0, in_if.delay_counts};
  assign sat_wake = sum_full[TIME_W] ? TIME_MAX : sum_full[TIME_W-1:0];

  // Single entry read port.
  always_comb begin
    unique case (state_r)
      S_SHIFT: rd_idx = idx_m1[IDX_W-1:0];
      S_SUM:   rd_idx = '0;
      default: rd_idx = idx_r[IDX_W-1:0];
    endcase
  end

  assign rd_wake  = wake_q[rd_idx];
  assign rd_owner = owner_q[rd_idx];

  // The shared comparator. While checking a sleep request it tests
  // now <= wake; otherwise it tests the addressed entry against the key.
  assign cmp_a = (state_r == S_CHK) ? now_r : rd_wake;
  assign le    = cmp_a <= key_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    dst_nxt    = dst_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    now_nxt    = now_r;
    id_nxt     = id_r;
    cmp_nxt    = cmp_r;
    irq_en_nxt = irq_en_r;
    in_if.ready = 1'b0;

    emit     = 1'b0;
    e_status = ST_SUMMARY;
    e_id     = '0;
    e_wake   = '0;
    e_cmp    = cmp_r;
    e_cw     = 1'b0;
    e_irq    = IRQ_NONE;
    e_last   = 1'b1;

    wr_en    = 1'b0;
    wr_idx   = rd_idx;
    wr_wake  = rd_wake;
    wr_owner = rd_owner;

    unique case (state_r)
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          key_nxt   = in_if.req_type ? in_if.now_time : sat_wake;
          now_nxt   = in_if.now_time;
          id_nxt    = in_if.alarm_id;
          idx_nxt   = '0;
          state_nxt = in_if.req_type ? S_POP : S_CHK;
        end
      end

      S_CHK: begin
        e_id   = id_r;
        e_wake = key_r;
        if (!le) begin
          if (out_free) begin
            emit      = 1'b1;
            e_status  = ST_PAST;
            state_nxt = S_IDLE;
          end
        end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          if (out_free) begin
            emit      = 1'b1;
            e_status  = ST_FULL;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = S_FIND;
        end
      end

      // Walk past every entry due no later than the new alarm.
      S_FIND: begin
        if (in_range && le) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          pos_nxt   = idx_r[IDX_W-1:0];
          idx_nxt   = count_r;
          state_nxt = S_SHIFT;
        end
      end

      // Move entries up one place from the tail down to the insert point.
      S_SHIFT: begin
        if (idx_r > CNT_W'(pos_r)) begin
          wr_en   = 1'b1;
          wr_idx  = idx_r[IDX_W-1:0];
          idx_nxt = idx_m1;
        end else if (out_free) begin
          wr_en      = 1'b1;
          wr_idx     = pos_r;
          wr_wake    = key_r;
          wr_owner   = id_r;
          count_nxt  = count_r + CNT_W'(1);
          irq_en_nxt = 1'b1;
          emit       = 1'b1;
          e_status   = ST_QUEUED;
          e_id       = id_r;
          e_wake     = key_r;
          e_irq      = irq_en_r ? IRQ_NONE : IRQ_ENABLED;
          if (pos_r == '0) begin
            cmp_nxt = key_r;
            e_cmp   = key_r;
            e_cw    = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      // Report due entries from the head; idx ends at the number popped.
      S_POP: begin
        if (in_range && le) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = ST_WOKEN;
            e_id     = rd_owner;
            e_wake   = rd_wake;
            e_last   = 1'b0;
            idx_nxt  = idx_r + CNT_W'(1);
          end
        end else begin
          dst_nxt   = '0;
          state_nxt = S_COMPACT;
        end
      end

      // Copy the remaining entries down to the head.
      S_COMPACT: begin
        if (in_range) begin
          wr_en   = 1'b1;
          wr_idx  = dst_r[IDX_W-1:0];
          idx_nxt = idx_r + CNT_W'(1);
          dst_nxt = dst_r + CNT_W'(1);
        end else begin
          count_nxt = dst_r;
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        if (out_free) begin
          emit = 1'b1;
          if (count_r != '0) begin
            cmp_nxt = rd_wake;
            e_cmp   = rd_wake;
            e_cw    = 1'b1;
          end else begin
            e_irq      = irq_en_r ? IRQ_DISABLED : IRQ_NONE;
            irq_en_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_r       <= TIME_MAX;
      irq_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_r       <= cmp_nxt;
      irq_en_r    <= irq_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    dst_r <= dst_nxt;
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    now_r <= now_nxt;
    id_r  <= id_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_id_r     <= e_id;
      out_wake_r   <= e_wake;
      out_cmp_r    <= e_cmp;
      out_cw_r     <= e_cw;
      out_irq_r    <= e_irq;
      out_last_r   <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wake_q[wr_idx]  <= wr_wake;
      owner_q[wr_idx] <= wr_owner;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.woken_id        = out_id_r;
  assign out_if.wake_time       = out_wake_r;
  assign out_if.compare_value   = out_cmp_r;
  assign out_if.compare_written = out_cw_r;
  assign out_if.irq_change      = out_irq_r;
  assign out_if.last            = out_last_r;

`ifndef SYNTHESIS
  // A queue holding alarms always has the timer interrupt enabled.
  a_irq_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> irq_en_r)
    else $error("queue holds alarms while the interrupt is disabled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_woken_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_WOKEN) |-> !out_last_r)
    else $error("woken alarm word marked as last");

  // A new head loads the compare register with its own wake time.
  a_head_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_QUEUED && out_cw_r) |->
      (out_cmp_r == out_wake_r))
    else $error("new head did not load the compare register");
`endif

endmodule

[tb/dsaq_tb_pkg.sv]
// Request codes shared by the alarm queue testbench and its checker.
// No dependencies.
`timescale 1ns / 1ps

package dsaq_tb_pkg;

  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

endpackage

[tb/dsaq_checker.sv]
// Scoreboard for the alarm queue: models the sorted queue, the compare register
// and the interrupt enable, and checks every result word in order.
// Depends on dsaq_pkg, dsaq_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module dsaq_checker import dsaq_pkg::*, dsaq_tb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dsaq_in_if   in_ch,
  dsaq_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     woken_id;
    logic [TIME_W-1:0]   wake_time;
    logic [TIME_W-1:0]   compare_value;
    logic                compare_written;
    logic [IRQ_W-1:0]    irq_change;
    logic                last;
  } result_word_t;

  logic [TIME_W-1:0] alarm_wake [QUEUE_DEPTH];
  logic [ID_W-1:0]   alarm_owner[QUEUE_DEPTH];
  int                alarm_count;
  logic [TIME_W-1:0] cmp_reg;
  logic              irq_on;
  result_word_t      expected_words[$];

  // The compare value of a word is the register as it stands when the word is made.
  function automatic void push_word(input logic [STATUS_W-1:0] status,
                                    input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] wake,
                                    input logic wrote, input logic [IRQ_W-1:0] irq,
                                    input logic last);
    result_word_t w;
    w.status          = status;
    w.woken_id        = id;
    w.wake_time       = wake;
    w.compare_value   = cmp_reg;
    w.compare_written = wrote;
    w.irq_change      = irq;
    w.last            = last;
    expected_words.push_back(w);
  endfunction

  task automatic predict_request(input logic rt, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] base,
                                 input logic [TIME_W-1:0] delay,
                                 input logic [TIME_W-1:0] now);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] wake;
    logic [IRQ_W-1:0]  irq;
    int                pos;
    int                popped;
    begin
      if (rt == REQ_SLEEP) begin
        sum  = {1'b0, base} + {1'b0, delay};
        wake = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        if (wake < now) begin
          push_word(ST_PAST, id, wake, 1'b0, IRQ_NONE, 1'b1);
        end else if (alarm_count >= QUEUE_DEPTH) begin
          push_word(ST_FULL, id, wake, 1'b0, IRQ_NONE, 1'b1);
        end else begin
          // Equal wake times keep arrival order, so the new alarm goes behind them.
          pos = 0;
          while (pos < alarm_count && alarm_wake[pos] <= wake) pos++;
          for (int i = alarm_count; i > pos; i--) begin
            alarm_wake[i]  = alarm_wake[i-1];
            alarm_owner[i] = alarm_owner[i-1];
          end
          alarm_wake[pos]  = wake;
          alarm_owner[pos] = id;
          alarm_count++;
          if (pos == 0) cmp_reg = wake;
          irq    = irq_on ? IRQ_NONE : IRQ_ENABLED;
          irq_on = 1'b1;
          push_word(ST_QUEUED, id, wake, pos == 0, irq, 1'b1);
        end
      end else if (alarm_count == 0) begin
        push_word(ST_SUMMARY, '0, '0, 1'b0, IRQ_NONE, 1'b1);
      end else begin
        popped = 0;
        while (popped < alarm_count && alarm_wake[popped] <= now) begin
          push_word(ST_WOKEN, alarm_owner[popped], alarm_wake[popped], 1'b0, IRQ_NONE, 1'b0);
          popped++;
        end
        for (int i = popped; i < alarm_count; i++) begin
          alarm_wake[i-popped]  = alarm_wake[i];
          alarm_owner[i-popped] = alarm_owner[i];
        end
        alarm_count -= popped;
        if (alarm_count > 0) begin
          cmp_reg = alarm_wake[0];
          push_word(ST_SUMMARY, '0, '0, 1'b1, IRQ_NONE, 1'b1);
        end else begin
          irq    = irq_on ? IRQ_DISABLED : IRQ_NONE;
          irq_on = 1'b0;
          push_word(ST_SUMMARY, '0, '0, 1'b0, irq, 1'b1);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_word_t got;
    result_word_t exp;
    if (!rst_n) begin
      alarm_count = 0;
      cmp_reg     = TIME_MAX;
      irq_on      = 1'b0;
      expected_words.delete();
      fail_count  = 0;
      pending     = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_request(in_ch.req_type, in_ch.alarm_id, in_ch.base_time,
                        in_ch.delay_counts, in_ch.now_time);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status          = out_ch.status;
        got.woken_id        = out_ch.woken_id;
        got.wake_time       = out_ch.wake_time;
        got.compare_value   = out_ch.compare_value;
        got.compare_written = out_ch.compare_written;
        got.irq_change      = out_ch.irq_change;
        got.last            = out_ch.last;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result word: status %0d id %02h wake %h cmp %h cw %0d irq %0d last %0d",
                     got.status, got.woken_id, got.wake_time, got.compare_value,
                     got.compare_written, got.irq_change, got.last);
          end
          fail_count++;
        end else begin
          exp = expected_words.pop_front();
          if (got.status !== exp.status || got.woken_id !== exp.woken_id ||
              got.wake_time !== exp.wake_time || got.compare_value !== exp.compare_value ||
              got.compare_written !== exp.compare_written ||
              got.irq_change !== exp.irq_change || got.last !== exp.last) begin
            if (fail_count < 10) begin
              $display("mismatch exp: status %0d id %02h wake %h cmp %h cw %0d irq %0d last %0d",
                       exp.status, exp.woken_id, exp.wake_time, exp.compare_value,
                       exp.compare_written, exp.irq_change, exp.last);
              $display("         got: status %0d id %02h wake %h cmp %h cw %0d irq %0d last %0d",
                       got.status, got.woken_id, got.wake_time, got.compare_value,
                       got.compare_written, got.irq_change, got.last);
            end
            fail_count++;
          end
        end
      end
      pending = expected_words.size();
    end
  end

endmodule

[tb/tb_deadline_sorted_alarm_queue.sv]
// Top of the alarm queue testbench: clock, reset, request stimulus and the
// result receiver. Depends on dsaq_pkg, dsaq_tb_pkg, the interfaces and dsaq_checker.
`timescale 1ns / 1ps

module tb_deadline_sorted_alarm_queue import dsaq_pkg::*, dsaq_tb_pkg::*; ();

  localparam int RANDOM_ITEMS = 240;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   pressure_go;
  bit   calm;

  dsaq_in_if  in_ch ();
  dsaq_out_if out_ch ();

  deadline_sorted_alarm_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  dsaq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offers one request word and returns at the edge where it is taken.
  task automatic offer(input logic rt, input logic [ID_W-1:0] id,
                       input logic [TIME_W-1:0] base, input logic [TIME_W-1:0] delay,
                       input logic [TIME_W-1:0] now);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= rt;
    in_ch.alarm_id     <= id;
    in_ch.base_time    <= base;
    in_ch.delay_counts <= delay;
    in_ch.now_time     <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off once the sender asks for it.
  initial begin
    int hold_cnt;
    hold_cnt     = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pressure_go && hold_cnt < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] tnow;
    int                pick;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_SLEEP;
    in_ch.alarm_id     = '0;
    in_ch.base_time    = '0;
    in_ch.delay_counts = '0;
    in_ch.now_time     = '0;
    rst_n              = 1'b0;
    pressure_go        = 1'b0;
    calm               = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-queue interrupt, wake equal to now at both ends, past and saturating sleeps.
    offer(REQ_CHECK, 8'h00, '0, '0, '0);
    offer(REQ_SLEEP, 8'h00, '0, '0, '0);
    offer(REQ_SLEEP, 8'hFF, TIME_MAX, TIME_MAX, TIME_MAX);
    offer(REQ_SLEEP, 8'h21, 64'd100, 64'd5, 64'd200);
    offer(REQ_SLEEP, 8'h22, TIME_MAX, 64'd1, '0);
    offer(REQ_SLEEP, 8'h23, 64'd50, 64'd50, 64'd10);
    offer(REQ_CHECK, 8'h00, '0, '0, 64'd5);
    offer(REQ_CHECK, 8'h00, '0, '0, TIME_MAX);

    // Fill with repeated wake times, overflow it, then drain it in one interrupt.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offer(REQ_SLEEP, ID_W'(8'h10 + i), 64'd1000, TIME_W'((i * 7 % 5) * 10),
            64'd1000);
    end
    offer(REQ_SLEEP, 8'hAA, 64'd2000, '0, '0);
    offer(REQ_SLEEP, 8'h55, '0, '0, 64'd5);
    offer(REQ_CHECK, 8'h00, '0, '0, 64'd1040);

    tnow = rand64();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 80) pressure_go = 1'b1;
      calm = (n >= 140 && n < 190);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        tnow = tnow + TIME_W'($urandom_range(0, 20));
        offer(REQ_SLEEP, ID_W'($urandom_range(0, 255)),
              tnow - TIME_W'($urandom_range(0, 60)),
              TIME_W'($urandom_range(0, 200)), tnow);
      end else if (pick < 75) begin
        tnow = tnow + TIME_W'($urandom_range(0, 150));
        offer(REQ_CHECK, ID_W'($urandom_range(0, 255)), rand64(), rand64(), tnow);
      end else if (pick < 85) begin
        offer(REQ_SLEEP, ID_W'($urandom_range(0, 255)), rand64(), rand64(), rand64());
      end else if (pick < 92) begin
        offer(REQ_CHECK, ID_W'($urandom_range(0, 255)), rand64(), rand64(), rand64());
      end else begin
        // Jump to a fresh point on the time line.
        tnow = rand64();
        offer(REQ_SLEEP, ID_W'($urandom_range(0, 255)), tnow,
              TIME_W'($urandom_range(0, 1000)), tnow);
      end
    end
    calm        = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
